[rtl/bvr_pkg.sv]
// ----------------------------------------------------------------------------
// bvr_pkg
// shared types, codes and widths of the bounding volume relation block
// ----------------------------------------------------------------------------
package bvr_pkg;

    // number format of one coordinate or radius (signed, 6 fraction bits at 16)
    localparam int COORD_WIDTH = 16;
    localparam int WORD_WIDTH  = 48;
    localparam int OP_WIDTH    = 3;
    localparam int REL_WIDTH   = 2;
    localparam int AXES        = 3;

    // entries of the queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    typedef logic [OP_WIDTH-1:0]            op_t;
    typedef logic [WORD_WIDTH-1:0]          word_t;
    typedef logic [REL_WIDTH-1:0]           rel_t;
    typedef logic signed [COORD_WIDTH-1:0]  coord_t;
    typedef logic signed [COORD_WIDTH:0]    diff_t;
    typedef logic [2*COORD_WIDTH:0]         square_t;
    typedef logic [2*COORD_WIDTH+2:0]       dist_t;
    typedef logic [QCNT_WIDTH-1:0]          qcnt_t;

    // pair types
    localparam op_t OP_SPHERE_SPHERE = 3'd0;
    localparam op_t OP_SPHERE_BOX    = 3'd1;
    localparam op_t OP_BOX_SPHERE    = 3'd2;
    localparam op_t OP_BOX_BOX       = 3'd3;

    // relation codes
    localparam rel_t REL_SEPARATE     = 2'd0;
    localparam rel_t REL_ADJACENT     = 2'd1;
    localparam rel_t REL_INTERSECTING = 2'd2;
    localparam rel_t REL_UNUSED       = 2'd3;

    // classified item handed from front to back
    typedef struct packed {
        logic               is_ss;
        diff_t [AXES-1:0]   d;
        diff_t              rs;
        rel_t               rel;
    } item_t;

    // queue status seen by the top level
    typedef struct packed {
        qcnt_t  level;
        logic   full;
        logic   empty;
    } qstat_t;

endpackage

[rtl/bvr_if.sv]
// ----------------------------------------------------------------------------
// bvr_req_if / bvr_rsp_if
// valid/ready channels for region pairs and their relation
// ----------------------------------------------------------------------------
interface bvr_req_if;
    import bvr_pkg::*;

    logic   valid;
    logic   ready;
    op_t    operation;
    word_t  first_a;
    word_t  second_a;
    word_t  first_b;
    word_t  second_b;

    modport source (
        output valid, operation, first_a, second_a, first_b, second_b,
        input  ready
    );
    modport sink (
        input  valid, operation, first_a, second_a, first_b, second_b,
        output ready
    );
endinterface

interface bvr_rsp_if;
    import bvr_pkg::*;

    logic   valid;
    logic   ready;
    rel_t   relation;

    modport source (
        output valid, relation,
        input  ready
    );
    modport sink (
        input  valid, relation,
        output ready
    );
endinterface

[rtl/bounding_volume_relation.sv]
// ----------------------------------------------------------------------------
// bounding_volume_relation
// separate / adjacent / intersecting test between two spheres or boxes
// ----------------------------------------------------------------------------
// One region pair per transfer, one relation per pair, in order. The block
// takes a new pair every cycle and gives one result every cycle when the
// response side is ready; each pair passes through the input register, a
// queue entry, the squaring stage and the result register. The front
// registers the pair, puts box corners in order and
// settles sphere-box and box-box pairs per axis; sphere-sphere pairs leave
// the front as center differences and a radius sum. A two-entry queue sits
// between front and back, so the request side keeps flowing for a while
// when the response side stalls. The back squares the sphere terms (four
// 17x17 multipliers at the default coordinate width), then compares the
// squared distance with the squared radius sum into the result register.
// Coordinates are signed fixed point of COORD_WIDTH bits (Q10.6 at 16),
// packed x,y,z from bit 0; a sphere radius sits in the low coordinate slot.
// Operation codes 4 to 7 mean a region is absent and give separate. There
// is no configuration and no state beyond the pipeline registers and queue.
// ----------------------------------------------------------------------------
module bounding_volume_relation (
    input  logic        clk,
    input  logic        rst_n,
    bvr_req_if.sink     req,
    bvr_rsp_if.source   rsp
);
    import bvr_pkg::*;

    // front to queue
    logic   f_valid;
    logic   f_ready;
    item_t  f_item;

    // queue to back
    logic   b_valid;
    logic   b_ready;
    item_t  b_item;

    qstat_t qstat;

    // accept and classify
    bvr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (f_valid),
        .q_ready (f_ready),
        .q_item  (f_item)
    );

    // decouples the two sides
    bvr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_item  (b_item),
        .stat     (qstat)
    );

    // squaring, compare and result register
    bvr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (b_valid),
        .q_ready (b_ready),
        .q_item  (b_item),
        .rsp     (rsp)
    );

    // never more entries than the queue holds
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.level <= qcnt_t'(QUEUE_DEPTH))
        else $error("queue level beyond depth");

    // the back sees an item exactly when the queue holds one
    a_queue_head: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid == (qstat.level != '0))
        else $error("queue head valid disagrees with level");

    // a full queue refuses the front, so a held front item stays
    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (f_valid && qstat.full) |=> f_valid)
        else $error("front item dropped while queue full");

    // the unused relation code never goes out
    a_rel_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.relation != REL_UNUSED)
        else $error("unused relation code on response");

endmodule

[rtl/bvr_front.sv]
// ----------------------------------------------------------------------------
// bvr_front
// takes a region pair, orders box corners and classifies per axis
// ----------------------------------------------------------------------------
module bvr_front (
    input  logic            clk,
    input  logic            rst_n,
    bvr_req_if.sink         req,
    output logic            q_valid,
    input  logic            q_ready,
    output bvr_pkg::item_t  q_item
);
    import bvr_pkg::*;

    typedef logic [AXES*COORD_WIDTH-1:0]   packed_t;
    typedef logic signed [COORD_WIDTH+1:0] wide_t;

    logic   valid_reg;
    logic   valid_next;
    op_t    op_reg;
    word_t  fa_reg;
    word_t  sa_reg;
    word_t  fb_reg;
    word_t  sb_reg;
    logic   take;
    item_t  item;

    // coordinate k of a packed word, missing high bits read as zero
    function automatic coord_t get_coord(word_t w, int k);
        packed_t wide;
        wide = packed_t'(w);
        return coord_t'(wide[k*COORD_WIDTH +: COORD_WIDTH]);
    endfunction

    function automatic rel_t combine(rel_t r0, rel_t r1, rel_t r2);
        rel_t res;
        if (r0 == REL_SEPARATE || r1 == REL_SEPARATE || r2 == REL_SEPARATE)
            res = REL_SEPARATE;
        else if (r0 == REL_ADJACENT || r1 == REL_ADJACENT || r2 == REL_ADJACENT)
            res = REL_ADJACENT;
        else
            res = REL_INTERSECTING;
        return res;
    endfunction

    // center against box grown by the radius on one axis
    function automatic rel_t sb_axis(coord_t p, coord_t b1, coord_t b2, coord_t r);
        coord_t mn;
        coord_t mx;
        wide_t  lo;
        wide_t  hi;
        wide_t  pe;
        rel_t   res;
        mn = (b1 < b2) ? b1 : b2;
        mx = (b1 < b2) ? b2 : b1;
        lo = wide_t'(mn) - wide_t'(r);
        hi = wide_t'(mx) + wide_t'(r);
        pe = wide_t'(p);
        if (pe > lo) begin
            if (pe > hi)
                res = REL_SEPARATE;
            else if (pe < hi)
                res = REL_INTERSECTING;
            else
                res = REL_ADJACENT;
        end
        else if (pe < lo)
            res = REL_SEPARATE;
        else
            res = REL_ADJACENT;
        return res;
    endfunction

    // interval overlap on one axis
    function automatic rel_t bb_axis(coord_t a1, coord_t a2, coord_t b1, coord_t b2);
        coord_t alo;
        coord_t ahi;
        coord_t blo;
        coord_t bhi;
        rel_t   res;
        alo = (a1 < a2) ? a1 : a2;
        ahi = (a1 < a2) ? a2 : a1;
        blo = (b1 < b2) ? b1 : b2;
        bhi = (b1 < b2) ? b2 : b1;
        if (ahi < blo || bhi < alo)
            res = REL_SEPARATE;
        else if (ahi == blo || bhi == alo)
            res = REL_ADJACENT;
        else
            res = REL_INTERSECTING;
        return res;
    endfunction

    function automatic rel_t sphere_box(word_t c, word_t r, word_t bmin, word_t bmax);
        rel_t ax [AXES];
        for (int k = 0; k < AXES; k++)
            ax[k] = sb_axis(get_coord(c, k), get_coord(bmin, k), get_coord(bmax, k),
                            get_coord(r, 0));
        return combine(ax[0], ax[1], ax[2]);
    endfunction

    function automatic rel_t box_box(word_t amin, word_t amax, word_t bmin, word_t bmax);
        rel_t ax [AXES];
        for (int k = 0; k < AXES; k++)
            ax[k] = bb_axis(get_coord(amin, k), get_coord(amax, k),
                            get_coord(bmin, k), get_coord(bmax, k));
        return combine(ax[0], ax[1], ax[2]);
    endfunction

    assign req.ready = !valid_reg || q_ready;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (q_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg <= req.operation;
            fa_reg <= req.first_a;
            sa_reg <= req.second_a;
            fb_reg <= req.first_b;
            sb_reg <= req.second_b;
        end
    end

    always_comb
    begin
        item.is_ss = 1'b0;
        item.d     = '0;
        item.rs    = '0;
        item.rel   = REL_SEPARATE;
        case (op_reg)
            OP_SPHERE_SPHERE:
            begin
                item.is_ss = 1'b1;
                for (int k = 0; k < AXES; k++)
                    item.d[k] = diff_t'(get_coord(fa_reg, k)) - diff_t'(get_coord(fb_reg, k));
                item.rs = diff_t'(get_coord(sa_reg, 0)) + diff_t'(get_coord(sb_reg, 0));
            end
            OP_SPHERE_BOX: item.rel = sphere_box(fa_reg, sa_reg, fb_reg, sb_reg);
            OP_BOX_SPHERE: item.rel = sphere_box(fb_reg, sb_reg, fa_reg, sa_reg);
            OP_BOX_BOX:    item.rel = box_box(fa_reg, sa_reg, fb_reg, sb_reg);
            default:       item.rel = REL_SEPARATE;
        endcase
    end

    assign q_valid = valid_reg;
    assign q_item  = item;

endmodule

[rtl/bvr_queue.sv]
// ----------------------------------------------------------------------------
// bvr_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module bvr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  bvr_pkg::item_t  wr_item,
    output logic            rd_valid,
    input  logic            rd_ready,
    output bvr_pkg::item_t  rd_item,
    output bvr_pkg::qstat_t stat
);
    import bvr_pkg::*;

    typedef logic [QPTR_WIDTH-1:0] ptr_t;

    item_t  mem [QUEUE_DEPTH];
    ptr_t   wr_ptr_reg;
    ptr_t   wr_ptr_next;
    ptr_t   rd_ptr_reg;
    ptr_t   rd_ptr_next;
    qcnt_t  count_reg;
    qcnt_t  count_next;
    logic   push;
    logic   pop;

    function automatic ptr_t bump(ptr_t p);
        ptr_t res;
        if (p == ptr_t'(QUEUE_DEPTH - 1))
            res = '0;
        else
            res = p + ptr_t'(1);
        return res;
    endfunction

    assign wr_ready = (count_reg != qcnt_t'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + qcnt_t'(1);
        else if (pop && !push)
            count_next = count_reg - qcnt_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_item;
    end

    assign stat.level = count_reg;
    assign stat.full  = !wr_ready;
    assign stat.empty = !rd_valid;

endmodule

[rtl/bvr_back.sv]
// ----------------------------------------------------------------------------
// bvr_back
// squares the sphere terms, compares distances and holds the result
// ----------------------------------------------------------------------------
module bvr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  bvr_pkg::item_t  q_item,
    bvr_rsp_if.source       rsp
);
    import bvr_pkg::*;

    typedef logic signed [2*COORD_WIDTH+1:0] prod_t;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       s1_is_ss_reg;
    rel_t       s1_rel_reg;
    square_t    s1_sq_reg [AXES];
    square_t    s1_rsq_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    rel_t       out_rel_reg;
    rel_t       out_rel_next;
    logic       adv1;
    logic       adv2;
    prod_t      prod [AXES];
    prod_t      rprod;
    dist_t      dist_sum;
    dist_t      rsq;

    assign adv2    = !out_valid_reg || rsp.ready;
    assign adv1    = !s1_valid_reg || adv2;
    assign q_ready = adv1;

    always_comb
    begin
        for (int k = 0; k < AXES; k++)
            prod[k] = $signed(q_item.d[k]) * $signed(q_item.d[k]);
        rprod = $signed(q_item.rs) * $signed(q_item.rs);
    end

    always_comb
    begin
        s1_valid_next  = adv1 ? q_valid : s1_valid_reg;
        out_valid_next = adv2 ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_is_ss_reg <= q_item.is_ss;
            s1_rel_reg   <= q_item.rel;
            for (int k = 0; k < AXES; k++)
                s1_sq_reg[k] <= prod[k][2*COORD_WIDTH:0];
            s1_rsq_reg <= rprod[2*COORD_WIDTH:0];
        end
    end

    // squared center distance against squared radius sum
    always_comb
    begin
        dist_sum = dist_t'(s1_sq_reg[0]) + dist_t'(s1_sq_reg[1]) + dist_t'(s1_sq_reg[2]);
        rsq      = dist_t'(s1_rsq_reg);
        if (!s1_is_ss_reg)
            out_rel_next = s1_rel_reg;
        else if (dist_sum < rsq)
            out_rel_next = REL_INTERSECTING;
        else if (dist_sum > rsq)
            out_rel_next = REL_SEPARATE;
        else
            out_rel_next = REL_ADJACENT;
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
            out_rel_reg <= out_rel_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.relation = out_rel_reg;

endmodule

[tb/sv/bounding_volume_relation_tb.sv]
// ----------------------------------------------------------------------------
// bounding_volume_relation_tb
// self-checking bench for the sphere / box relation block: directed corner
// pairs then ~950 mostly well-formed random pairs, random idling on both
// channels, one long response stall and two drain pauses, every relation
// compared in order against a scoreboard that predicts it
// ----------------------------------------------------------------------------
module bounding_volume_relation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bvr_pkg::*;

    // absent-region selector codes (4 to 7 all mean no test)
    localparam op_t OP_REGION_ABSENT = 3'd4;
    localparam op_t OP_SELECT_LAST   = 3'd7;

    // fixed point helpers at the package width (Q10.6 at 16 bits)
    localparam int FRAC_ONE = 1 << 6;
    localparam int CMAX     = (1 << (COORD_WIDTH - 1)) - 1;
    localparam int CMIN     = -(1 << (COORD_WIDTH - 1));

    // idling and pressure
    localparam int IDLE_MAX    = 18;
    localparam int HOLD_CYCLES = 200;
    localparam int TAIL_CYCLES = 10;

    typedef rel_t [AXES-1:0] axis_rels_t;

    typedef struct {
        op_t    op;
        word_t  first_a;
        word_t  second_a;
        word_t  first_b;
        word_t  second_b;
    } pair_t;

    // ------------------------------------------------------------------------
    // scoreboard: predicts one relation per accepted pair, checks in order
    // ------------------------------------------------------------------------
    class relation_scoreboard;
        rel_t pending_relations[$];
        int   mismatches;

        function new();
            mismatches = 0;
        endfunction

        // signed coordinate k of a packed word; bits past the word read as zero
        static function longint coord_of(word_t w, int k);
            logic [63:0] t;
            logic [63:0] mask;
            mask = (64'd1 << COORD_WIDTH) - 64'd1;
            t = (64'(w) >> (k * COORD_WIDTH)) & mask;
            if (t[COORD_WIDTH-1])
                return longint'(t) - (longint'(1) << COORD_WIDTH);
            return longint'(t);
        endfunction

        // any axis separate wins, then any axis adjacent
        static function rel_t combine_axes(axis_rels_t axes);
            bit any_adj;
            any_adj = 1'b0;
            for (int k = 0; k < AXES; k++)
            begin
                if (axes[k] == REL_SEPARATE)
                    return REL_SEPARATE;
                if (axes[k] == REL_ADJACENT)
                    any_adj = 1'b1;
            end
            return any_adj ? REL_ADJACENT : REL_INTERSECTING;
        endfunction

        // center against the box grown by the radius (radius taken as given)
        static function rel_t sphere_box(word_t center, word_t radius,
                                         word_t bmin, word_t bmax);
            axis_rels_t axes;
            longint r, p, b1, b2, lo, hi;
            r = coord_of(radius, 0);
            for (int k = 0; k < AXES; k++)
            begin
                p  = coord_of(center, k);
                b1 = coord_of(bmin, k);
                b2 = coord_of(bmax, k);
                lo = ((b1 < b2) ? b1 : b2) - r;
                hi = ((b1 < b2) ? b2 : b1) + r;
                // lower bound first, so an inverted interval still resolves
                if (p > lo)
                    axes[k] = (p > hi) ? REL_SEPARATE :
                              (p < hi) ? REL_INTERSECTING : REL_ADJACENT;
                else if (p < lo)
                    axes[k] = REL_SEPARATE;
                else
                    axes[k] = REL_ADJACENT;
            end
            return combine_axes(axes);
        endfunction

        static function rel_t predict_relation(pair_t p);
            axis_rels_t axes;
            longint d, dist_sum, rs;
            longint a1, a2, b1, b2, alo, ahi, blo, bhi;
            case (p.op)
                OP_SPHERE_SPHERE:
                begin
                    dist_sum = 0;
                    for (int k = 0; k < AXES; k++)
                    begin
                        d = coord_of(p.first_a, k) - coord_of(p.first_b, k);
                        dist_sum += d * d;
                    end
                    rs = coord_of(p.second_a, 0) + coord_of(p.second_b, 0);
                    if (dist_sum < rs * rs)
                        return REL_INTERSECTING;
                    if (dist_sum > rs * rs)
                        return REL_SEPARATE;
                    return REL_ADJACENT;
                end
                OP_SPHERE_BOX:
                    return sphere_box(p.first_a, p.second_a, p.first_b, p.second_b);
                OP_BOX_SPHERE:
                    return sphere_box(p.first_b, p.second_b, p.first_a, p.second_a);
                OP_BOX_BOX:
                begin
                    for (int k = 0; k < AXES; k++)
                    begin
                        a1 = coord_of(p.first_a, k);
                        a2 = coord_of(p.second_a, k);
                        b1 = coord_of(p.first_b, k);
                        b2 = coord_of(p.second_b, k);
                        alo = (a1 < a2) ? a1 : a2;
                        ahi = (a1 < a2) ? a2 : a1;
                        blo = (b1 < b2) ? b1 : b2;
                        bhi = (b1 < b2) ? b2 : b1;
                        if (ahi < blo || bhi < alo)
                            axes[k] = REL_SEPARATE;
                        else if (ahi == blo || bhi == alo)
                            axes[k] = REL_ADJACENT;
                        else
                            axes[k] = REL_INTERSECTING;
                    end
                    return combine_axes(axes);
                end
                default:
                    return REL_SEPARATE;
            endcase
        endfunction

        function void note_pair(pair_t p);
            pending_relations.push_back(predict_relation(p));
        endfunction

        function void check_relation(rel_t got);
            rel_t want;
            if (pending_relations.size() == 0)
            begin
                mismatches++;
                $display("%0t ns relation with none pending: expected none, actual %0d",
                         $time, got);
                return;
            end
            want = pending_relations.pop_front();
            if (got !== want)
            begin
                mismatches++;
                $display("%0t ns relation mismatch: expected %0d, actual %0d",
                         $time, want, got);
            end
        endfunction

        function int outstanding();
            return pending_relations.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels, block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bvr_req_if req_ch ();
    bvr_rsp_if rsp_ch ();

    bounding_volume_relation dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    relation_scoreboard sb = new();

    // knobs shared between the main sequence and the response side
    int send_idle_max = IDLE_MAX;
    int recv_idle_max = IDLE_MAX;
    bit hold_request  = 1'b0;

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // pack x,y,z from bit 0, each truncated to the coordinate width
    function automatic word_t pack_xyz(int x, int y, int z);
        logic [63:0] t;
        logic [63:0] mask;
        int v[3];
        v = '{x, y, z};
        mask = (64'd1 << COORD_WIDTH) - 64'd1;
        t = '0;
        for (int k = 0; k < AXES; k++)
            t |= (64'(v[k]) & mask) << (k * COORD_WIDTH);
        return word_t'(t);
    endfunction

    function automatic word_t pack_all(int v);
        return pack_xyz(v, v, v);
    endfunction

    function automatic word_t random_word();
        return word_t'({$urandom, $urandom});
    endfunction

    function automatic pair_t make_pair(op_t op, word_t fa, word_t sa,
                                        word_t fb, word_t sb_w);
        pair_t p;
        p.op       = op;
        p.first_a  = fa;
        p.second_a = sa;
        p.first_b  = fb;
        p.second_b = sb_w;
        return p;
    endfunction

    // mostly well-formed pairs close to each other so all three relations
    // show up, a share built to touch exactly, the rest noise and absent
    function automatic pair_t random_pair();
        pair_t p;
        int kind, ax;
        int c_a[3], c_b[3], lo_a[3], hi_a[3], lo_b[3], hi_b[3];
        int m1[3], m2[3], n1[3], n2[3];
        int r_a, r_b;
        word_t rad_a, rad_b;
        kind = $urandom_range(0, 99);
        p.first_a  = random_word();
        p.second_a = random_word();
        p.first_b  = random_word();
        p.second_b = random_word();
        // raw noise over all selector codes and all bits
        if (kind < 8)
        begin
            p.op = op_t'($urandom_range(0, 7));
            return p;
        end
        // absent region
        if (kind < 16)
        begin
            p.op = OP_REGION_ABSENT + op_t'($urandom_range(0, 3));
            return p;
        end
        p.op = op_t'($urandom_range(0, 3));
        // full range coordinates on a real test
        if (kind < 22)
            return p;

        for (int k = 0; k < AXES; k++)
        begin
            c_a[k]  = $urandom_range(0, 600) - 300;
            c_b[k]  = $urandom_range(0, 600) - 300;
            lo_a[k] = $urandom_range(0, 600) - 300;
            hi_a[k] = lo_a[k] + $urandom_range(0, 300);
            lo_b[k] = $urandom_range(0, 600) - 300;
            hi_b[k] = lo_b[k] + $urandom_range(0, 300);
        end
        r_a = $urandom_range(0, 200);
        r_b = $urandom_range(0, 200);
        if ($urandom_range(0, 9) == 0)
            r_a = -r_a;
        if ($urandom_range(0, 9) == 0)
            r_b = -r_b;

        // exact contact on one axis
        if ($urandom_range(0, 2) == 0)
        begin
            ax = $urandom_range(0, 2);
            case (p.op)
                OP_SPHERE_SPHERE:
                begin
                    c_b = c_a;
                    c_b[ax] = c_a[ax] + r_a + r_b;
                end
                OP_SPHERE_BOX:
                begin
                    c_a = lo_b;
                    c_a[ax] = hi_b[ax] + r_a;
                end
                OP_BOX_SPHERE:
                begin
                    c_b = hi_a;
                    c_b[ax] = lo_a[ax] - r_b;
                end
                default:
                begin
                    lo_b[ax] = hi_a[ax];
                    hi_b[ax] = lo_b[ax] + $urandom_range(0, 300);
                end
            endcase
        end

        // corners swapped on some axes
        for (int k = 0; k < AXES; k++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                m1[k] = hi_a[k];
                m2[k] = lo_a[k];
            end
            else
            begin
                m1[k] = lo_a[k];
                m2[k] = hi_a[k];
            end
            if ($urandom_range(0, 4) == 0)
            begin
                n1[k] = hi_b[k];
                n2[k] = lo_b[k];
            end
            else
            begin
                n1[k] = lo_b[k];
                n2[k] = hi_b[k];
            end
        end

        // radius words carry junk above the radius
        rad_a = pack_xyz(r_a, $urandom_range(0, 65535), $urandom_range(0, 65535));
        rad_b = pack_xyz(r_b, $urandom_range(0, 65535), $urandom_range(0, 65535));

        case (p.op)
            OP_SPHERE_SPHERE:
                p = make_pair(p.op, pack_xyz(c_a[0], c_a[1], c_a[2]), rad_a,
                              pack_xyz(c_b[0], c_b[1], c_b[2]), rad_b);
            OP_SPHERE_BOX:
                p = make_pair(p.op, pack_xyz(c_a[0], c_a[1], c_a[2]), rad_a,
                              pack_xyz(n1[0], n1[1], n1[2]),
                              pack_xyz(n2[0], n2[1], n2[2]));
            OP_BOX_SPHERE:
                p = make_pair(p.op, pack_xyz(m1[0], m1[1], m1[2]),
                              pack_xyz(m2[0], m2[1], m2[2]),
                              pack_xyz(c_b[0], c_b[1], c_b[2]), rad_b);
            default:
                p = make_pair(p.op, pack_xyz(m1[0], m1[1], m1[2]),
                              pack_xyz(m2[0], m2[1], m2[2]),
                              pack_xyz(n1[0], n1[1], n1[2]),
                              pack_xyz(n2[0], n2[1], n2[2]));
        endcase
        return p;
    endfunction

    // offer one pair after the requested idle gap and hold it until the transfer;
    // valid only drops when a gap follows, so back-to-back pairs stream
    task automatic send_pair(pair_t p, int gap);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= p.op;
        req_ch.first_a   <= p.first_a;
        req_ch.second_a  <= p.second_a;
        req_ch.first_b   <= p.first_b;
        req_ch.second_b  <= p.second_b;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // sender stops offering until every predicted relation is back
    task automatic rest_until_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
            send_pair(random_pair(), $urandom_range(0, send_idle_max));
    endtask

    // ------------------------------------------------------------------------
    // monitor: both channels sampled at the edge, input noted before the
    // result is checked
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (req_ch.valid && req_ch.ready)
            sb.note_pair(make_pair(req_ch.operation, req_ch.first_a, req_ch.second_a,
                                   req_ch.first_b, req_ch.second_b));
        if (rsp_ch.valid && rsp_ch.ready)
            sb.check_relation(rsp_ch.relation);
    end

    // ------------------------------------------------------------------------
    // response side: random ready gaps per result, one long hold on request
    // ------------------------------------------------------------------------
    initial
    begin : response_side
        int hold;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else
                hold = $urandom_range(0, recv_idle_max);
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        pair_t directed[$];

        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= '0;
        req_ch.first_a   <= '0;
        req_ch.second_a  <= '0;
        req_ch.first_b   <= '0;
        req_ch.second_b  <= '0;
        rsp_ch.ready     <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // spheres: touching, overlapping, apart, 3-4-5 diagonal contact
        directed.push_back(make_pair(OP_SPHERE_SPHERE, pack_all(0), pack_xyz(FRAC_ONE, 0, 0),
            pack_xyz(2 * FRAC_ONE, 0, 0), pack_xyz(FRAC_ONE, 0, 0)));
        directed.push_back(make_pair(OP_SPHERE_SPHERE, pack_all(0),
            pack_xyz(3 * FRAC_ONE / 2, 0, 0), pack_xyz(2 * FRAC_ONE, 0, 0),
            pack_xyz(3 * FRAC_ONE / 2, 0, 0)));
        directed.push_back(make_pair(OP_SPHERE_SPHERE, pack_all(0),
            pack_xyz(FRAC_ONE / 2, 0, 0), pack_xyz(2 * FRAC_ONE, 0, 0),
            pack_xyz(FRAC_ONE / 2, 0, 0)));
        directed.push_back(make_pair(OP_SPHERE_SPHERE, pack_all(0),
            pack_xyz(2 * FRAC_ONE, 0, 0), pack_xyz(3 * FRAC_ONE, 4 * FRAC_ONE, 0),
            pack_xyz(3 * FRAC_ONE, 0, 0)));
        // spheres at the coordinate extremes
        directed.push_back(make_pair(OP_SPHERE_SPHERE, pack_all(CMAX), pack_xyz(CMAX, 0, 0),
            pack_all(CMIN), pack_xyz(CMAX, 0, 0)));
        // negative radii used as given: the square still touches
        directed.push_back(make_pair(OP_SPHERE_SPHERE, pack_all(0), pack_xyz(-FRAC_ONE, 0, 0),
            pack_xyz(2 * FRAC_ONE, 0, 0), pack_xyz(-FRAC_ONE, 0, 0)));
        directed.push_back(make_pair(OP_SPHERE_SPHERE, pack_all(CMIN), pack_xyz(CMIN, 0, 0),
            pack_all(CMIN), pack_xyz(CMIN, 0, 0)));

        // sphere with box 0..4: on the grown face, inside, beyond, below
        directed.push_back(make_pair(OP_SPHERE_BOX,
            pack_xyz(5 * FRAC_ONE, FRAC_ONE, FRAC_ONE), pack_xyz(FRAC_ONE, 0, 0),
            pack_all(0), pack_all(4 * FRAC_ONE)));
        directed.push_back(make_pair(OP_SPHERE_BOX, pack_all(2 * FRAC_ONE),
            pack_xyz(FRAC_ONE, 0, 0), pack_all(0), pack_all(4 * FRAC_ONE)));
        directed.push_back(make_pair(OP_SPHERE_BOX,
            pack_xyz(6 * FRAC_ONE, 2 * FRAC_ONE, 2 * FRAC_ONE), pack_xyz(FRAC_ONE, 0, 0),
            pack_all(0), pack_all(4 * FRAC_ONE)));
        directed.push_back(make_pair(OP_SPHERE_BOX,
            pack_xyz(-2 * FRAC_ONE, 2 * FRAC_ONE, 2 * FRAC_ONE), pack_xyz(FRAC_ONE, 0, 0),
            pack_all(0), pack_all(4 * FRAC_ONE)));
        // box corners swapped, center on the grown lower face
        directed.push_back(make_pair(OP_SPHERE_BOX,
            pack_xyz(-FRAC_ONE, 2 * FRAC_ONE, 2 * FRAC_ONE), pack_xyz(FRAC_ONE, 0, 0),
            pack_all(4 * FRAC_ONE), pack_all(0)));
        // negative radius inverts the grown interval
        directed.push_back(make_pair(OP_SPHERE_BOX, pack_all(3 * FRAC_ONE),
            pack_xyz(-3 * FRAC_ONE, 0, 0), pack_all(0), pack_all(4 * FRAC_ONE)));
        // junk above the radius is ignored
        directed.push_back(make_pair(OP_SPHERE_BOX, pack_all(2 * FRAC_ONE),
            pack_xyz(FRAC_ONE, -1, CMIN), pack_all(0), pack_all(4 * FRAC_ONE)));
        // box with sphere, touching
        directed.push_back(make_pair(OP_BOX_SPHERE, pack_all(0), pack_all(4 * FRAC_ONE),
            pack_xyz(5 * FRAC_ONE, 2 * FRAC_ONE, 2 * FRAC_ONE), pack_xyz(FRAC_ONE, 0, 0)));

        // boxes: containment, crossing, face contact, apart
        directed.push_back(make_pair(OP_BOX_BOX, pack_all(0), pack_all(8 * FRAC_ONE),
            pack_all(2 * FRAC_ONE), pack_all(3 * FRAC_ONE)));
        directed.push_back(make_pair(OP_BOX_BOX,
            pack_xyz(0, 3 * FRAC_ONE, 0), pack_xyz(8 * FRAC_ONE, 4 * FRAC_ONE, 8 * FRAC_ONE),
            pack_xyz(3 * FRAC_ONE, 0, 0), pack_xyz(4 * FRAC_ONE, 8 * FRAC_ONE, 8 * FRAC_ONE)));
        directed.push_back(make_pair(OP_BOX_BOX, pack_all(0), pack_all(4 * FRAC_ONE),
            pack_xyz(4 * FRAC_ONE, 0, 0), pack_xyz(8 * FRAC_ONE, 4 * FRAC_ONE, 4 * FRAC_ONE)));
        directed.push_back(make_pair(OP_BOX_BOX, pack_all(0), pack_all(4 * FRAC_ONE),
            pack_all(5 * FRAC_ONE), pack_all(8 * FRAC_ONE)));
        // zero-size box on a corner of a swapped box
        directed.push_back(make_pair(OP_BOX_BOX, pack_all(4 * FRAC_ONE),
            pack_all(4 * FRAC_ONE), pack_all(4 * FRAC_ONE), pack_all(0)));
        // full-range box against a point at its top corner
        directed.push_back(make_pair(OP_BOX_BOX, pack_all(CMIN), pack_all(CMAX),
            pack_all(CMAX), pack_all(CMAX)));

        // absent region overrides overlapping data
        directed.push_back(make_pair(OP_REGION_ABSENT, pack_all(0), pack_all(8 * FRAC_ONE),
            pack_all(0), pack_all(8 * FRAC_ONE)));
        directed.push_back(make_pair(OP_SELECT_LAST, '1, '1, '1, '1));
        // all-zero and all-one fields
        directed.push_back(make_pair(OP_SPHERE_SPHERE, '0, '0, '0, '0));
        directed.push_back(make_pair(OP_BOX_BOX, '1, '1, '1, '1));

        foreach (directed[i])
            send_pair(directed[i], $urandom_range(0, IDLE_MAX));

        // sender waits out everything in flight
        rest_until_drained();

        // random idling on both sides
        send_random(250);

        // streaming with no idling at all
        send_idle_max = 0;
        recv_idle_max = 0;
        send_random(200);

        // long response stall while the sender keeps offering back to back
        recv_idle_max = IDLE_MAX;
        hold_request  = 1'b1;
        send_random(150);
        rest_until_drained();

        // fast sender against a slow receiver, then the other way round
        send_idle_max = 2;
        send_random(175);
        send_idle_max = IDLE_MAX;
        recv_idle_max = 2;
        send_random(175);

        req_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
